// ===== rtl/asaf_pkg.sv =====
// Shared types and constants of the ADC sample ASCII framer.
`default_nettype none
package asaf_pkg;

    localparam int FifoDepth = 4;

    localparam logic [7:0] MarkerReset  = 8'd65;
    localparam logic [7:0] LineEndReset = 8'd10;
    localparam logic [3:0] UniChReset   = 4'd1;
    localparam logic [3:0] BipChReset   = 4'd6;

    localparam logic [7:0] AsciiZero  = 8'h30;
    localparam logic [7:0] AsciiMinus = 8'h2D;

    typedef enum logic [1:0] {
        CFG_MARKER   = 2'd0,
        CFG_LINE_END = 2'd1,
        CFG_UNI_CH   = 2'd2,
        CFG_BIP_CH   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_MINUS,
        PH_DIGIT,
        PH_END
    } phase_t;

    typedef struct packed {
        logic [7:0] marker;
        logic [7:0] line_end;
        logic [3:0] uni_ch;
        logic [3:0] bip_ch;
    } cfg_t;

    typedef struct packed {
        logic            bip;
        logic            neg;
        logic [1:0]      nd_m1;
        logic [3:0][3:0] digits;
        logic [3:0]      ch;
    } item_t;

endpackage
`default_nettype wire

// ===== rtl/asaf_front.sv =====
// Front end: takes samples, forms sign and magnitude and splits them into decimal digits.
`default_nettype none
module asaf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [9:0]     sample_code,
    input  wire asaf_pkg::cfg_t cfg,
    input  wire logic           fifo_full,
    output logic                wr_en,
    output asaf_pkg::item_t     wr_data
);

    logic        s1_valid_reg, s1_valid_next;
    logic        bip_turn_reg, bip_turn_next;
    logic        s1_bip_reg, s1_neg_reg, s1_th_reg;
    logic [9:0]  s1_r_reg;
    logic [3:0]  s1_ch_reg;

    logic        accept;
    logic        neg;
    logic [9:0]  mag;
    logic        th;
    logic [9:0]  r;

    logic [15:0] prod_h;
    logic [17:0] prod_q;
    logic [3:0]  hund;
    logic [6:0]  quot;
    logic [9:0]  ones_w;
    logic [6:0]  tens_w;

    assign full   = s1_valid_reg && fifo_full;
    assign wr_en  = s1_valid_reg && !fifo_full;
    assign accept = push && !full;

    always_comb
    begin
        neg = bip_turn_reg && sample_code[9];
        mag = neg ? 10'(~sample_code + 10'd1) : sample_code;
        th  = (mag >= 10'd1000);
        r   = th ? 10'(mag - 10'd1000) : mag;
        s1_valid_next = accept ? 1'b1 : (wr_en ? 1'b0 : s1_valid_reg);
        bip_turn_next = accept ? !bip_turn_reg : bip_turn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            bip_turn_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            bip_turn_reg <= bip_turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bip_reg <= bip_turn_reg;
            s1_neg_reg <= neg;
            s1_th_reg  <= th;
            s1_r_reg   <= r;
            s1_ch_reg  <= bip_turn_reg ? cfg.uni_ch : cfg.bip_ch;
        end
    end

    always_comb
    begin
        prod_h = 16'(s1_r_reg) * 16'd41;
        prod_q = 18'(s1_r_reg) * 18'd205;
        hund   = prod_h[15:12];
        quot   = prod_q[17:11];
        ones_w = 10'(s1_r_reg - (10'(quot) * 10'd10));
        tens_w = 7'(quot - (7'(hund) * 7'd10));

        wr_data.bip       = s1_bip_reg;
        wr_data.neg       = s1_neg_reg;
        wr_data.ch        = s1_ch_reg;
        wr_data.digits[3] = s1_th_reg ? 4'd1 : 4'd0;
        wr_data.digits[2] = hund;
        wr_data.digits[1] = tens_w[3:0];
        wr_data.digits[0] = ones_w[3:0];
        if (s1_th_reg)
            wr_data.nd_m1 = 2'd3;
        else if (hund != 4'd0)
            wr_data.nd_m1 = 2'd2;
        else if (quot != 7'd0)
            wr_data.nd_m1 = 2'd1;
        else
            wr_data.nd_m1 = 2'd0;
    end

endmodule
`default_nettype wire

// ===== rtl/asaf_fifo.sv =====
// Short item queue between the front end and the text sequencer.
`default_nettype none
module asaf_fifo #(
    parameter int DEPTH = asaf_pkg::FifoDepth
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire asaf_pkg::item_t wr_data,
    input  wire logic            rd_en,
    output asaf_pkg::item_t      rd_data,
    output logic                 full,
    output logic                 empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    asaf_pkg::item_t mem [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        if (wr_en && !rd_en)
            count_next = CntW'(count_reg + 1'b1);
        else if (rd_en && !wr_en)
            count_next = CntW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// ===== rtl/asaf_back.sv =====
// Back end: walks each queued item and sends its line one byte a beat into the result register.
`default_nettype none
module asaf_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire asaf_pkg::cfg_t  cfg,
    input  wire logic            fifo_empty,
    input  wire asaf_pkg::item_t head,
    output logic                 rd_en,
    output logic                 empty,
    input  wire logic            pop,
    output logic [7:0]           text_byte,
    output logic                 line_done,
    output logic [3:0]           next_channel
);

    asaf_pkg::phase_t phase_reg, phase_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] text_reg;
    logic       done_reg;
    logic [3:0] ch_reg;

    logic       fire;
    logic [7:0] byte_val;
    logic       done_val;
    logic [7:0] dig_byte;

    assign fire         = !fifo_empty && (!out_valid_reg || pop);
    assign empty        = !out_valid_reg;
    assign text_byte    = text_reg;
    assign line_done    = done_reg;
    assign next_channel = ch_reg;

    always_comb
    begin
        dig_byte       = asaf_pkg::AsciiZero | {4'h0, head.digits[2'(head.nd_m1 - cnt_reg)]};
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        byte_val       = cfg.line_end;
        done_val       = 1'b0;
        rd_en          = 1'b0;
        out_valid_next = fire || (out_valid_reg && !pop);
        case (phase_reg)
            asaf_pkg::PH_HEAD:
            begin
                if (head.bip)
                begin
                    byte_val = cfg.marker;
                    if (fire)
                        phase_next = head.neg ? asaf_pkg::PH_MINUS : asaf_pkg::PH_DIGIT;
                end
                else
                begin
                    byte_val = dig_byte;
                    if (fire)
                    begin
                        if (head.nd_m1 == cnt_reg)
                            phase_next = asaf_pkg::PH_END;
                        else
                        begin
                            cnt_next   = 2'(cnt_reg + 1'b1);
                            phase_next = asaf_pkg::PH_DIGIT;
                        end
                    end
                end
            end
            asaf_pkg::PH_MINUS:
            begin
                byte_val = asaf_pkg::AsciiMinus;
                if (fire)
                    phase_next = asaf_pkg::PH_DIGIT;
            end
            asaf_pkg::PH_DIGIT:
            begin
                byte_val = dig_byte;
                if (fire)
                begin
                    if (head.nd_m1 == cnt_reg)
                    begin
                        cnt_next   = 2'd0;
                        phase_next = asaf_pkg::PH_END;
                    end
                    else
                        cnt_next = 2'(cnt_reg + 1'b1);
                end
            end
            asaf_pkg::PH_END:
            begin
                byte_val = cfg.line_end;
                done_val = 1'b1;
                rd_en    = fire;
                if (fire)
                begin
                    cnt_next   = 2'd0;
                    phase_next = asaf_pkg::PH_HEAD;
                end
            end
            default:
            begin
                cnt_next   = 2'd0;
                phase_next = asaf_pkg::PH_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= asaf_pkg::PH_HEAD;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            text_reg <= byte_val;
            done_reg <= done_val;
            ch_reg   <= head.ch;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/adc_sample_ascii_framer.sv =====
// Top level of the ADC sample ASCII framer: configuration registers and the front, queue and back.
// A sample's first byte passes the front-end register, the queue and the result register.
// Throughput: one text byte per cycle unless pop stalls it; a sample's line is 2 to 6 bytes long.
// The byte sequencer in the back end, one byte a cycle into the result register, sets that rate.
// Reset (rst_n low, asynchronous) empties the queue and result register, restores the register
// defaults and makes the next sample unipolar.
`default_nettype none
module adc_sample_ascii_framer #(
    parameter int FIFO_DEPTH = asaf_pkg::FifoDepth
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [9:0] sample_code,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      text_byte,
    output logic            line_done,
    output logic [3:0]      next_channel,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    asaf_pkg::cfg_t  cfg_reg, cfg_next;
    asaf_pkg::item_t wr_data, rd_data;
    logic            wr_en, rd_en, fifo_full, fifo_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                asaf_pkg::CFG_MARKER:   cfg_next.marker   = cfg_data;
                asaf_pkg::CFG_LINE_END: cfg_next.line_end = cfg_data;
                asaf_pkg::CFG_UNI_CH:   cfg_next.uni_ch   = cfg_data[3:0];
                asaf_pkg::CFG_BIP_CH:   cfg_next.bip_ch   = cfg_data[3:0];
                default:                cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker   <= asaf_pkg::MarkerReset;
            cfg_reg.line_end <= asaf_pkg::LineEndReset;
            cfg_reg.uni_ch   <= asaf_pkg::UniChReset;
            cfg_reg.bip_ch   <= asaf_pkg::BipChReset;
        end
        else
            cfg_reg <= cfg_next;
    end

    asaf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_code (sample_code),
        .cfg         (cfg_reg),
        .fifo_full   (fifo_full),
        .wr_en       (wr_en),
        .wr_data     (wr_data)
    );

    asaf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    asaf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_empty   (fifo_empty),
        .head         (rd_data),
        .rd_en        (rd_en),
        .empty        (empty),
        .pop          (pop),
        .text_byte    (text_byte),
        .line_done    (line_done),
        .next_channel (next_channel)
    );

endmodule
`default_nettype wire

// ===== rtl/asaf_checker.sv =====
// Port-level assertions of the ADC sample ASCII framer and their binding to the top level.
`default_nettype none
module asaf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] text_byte,
    input wire logic       line_done,
    input wire logic [3:0] next_channel
);

    // A result that is not taken stays on the ports unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(text_byte) && $stable(line_done)
                              && $stable(next_channel)))
        else $error("result changed while stalled");

    // Every byte of one line carries the same channel code.
    a_line_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !line_done) |=> (empty || (next_channel == $past(next_channel))))
        else $error("channel code changed within a line");

    // The input side can only be full while results are waiting.
    a_full_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input full with no result waiting");

endmodule

bind adc_sample_ascii_framer asaf_checker u_asaf_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the ADC sample ASCII framer, driven from a table and then at random.
`timescale 1ns / 1ps
module tb_top;

    localparam int IdleLimit = 2000;
    localparam int DirRows   = 22;

    typedef struct packed {
        logic [7:0] chr;
        logic       done;
        logic [3:0] ch;
    } text_beat_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic [9:0] sample_code = '0;
    logic       empty;
    logic       pop         = 1'b0;
    logic [7:0] text_byte;
    logic       line_done;
    logic [3:0] next_channel;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index   = '0;
    logic [7:0] cfg_data    = '0;

    asaf_pkg::cfg_t shadow_cfg;
    logic       bip_turn;
    text_beat_t line_bytes_q [$];
    bit         no_gaps;
    int         fail_count;
    int         lines_sent;
    int         neg_lines;
    int         bytes_checked;
    int         settings_used;

    logic [9:0] dir_code [DirRows] = '{
        10'd0,   10'd0,    10'd1023, 10'd512, 10'd1,   10'd511, 10'd9,    10'd1023,
        10'd10,  10'd513,  10'd99,   10'd1014, 10'd100, 10'd1015, 10'd999, 10'd10,
        10'd1000, 10'd924, 10'd512,  10'd100, 10'd511, 10'd1
    };
    string dir_text [DirRows] = '{
        "0\n", "A0\n", "1023\n", "A-512\n", "", "A511\n", "", "A-1\n",
        "", "", "", "", "", "", "", "", "", "", "", "", "", ""
    };
    logic [3:0] dir_ch [DirRows] = '{
        4'd6, 4'd1, 4'd6, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };
    logic [9:0] edge_codes [10] = '{
        10'd0, 10'd1, 10'd9, 10'd10, 10'd99, 10'd100, 10'd511, 10'd512, 10'd513, 10'd1023
    };

    adc_sample_ascii_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_code  (sample_code),
        .empty        (empty),
        .pop          (pop),
        .text_byte    (text_byte),
        .line_done    (line_done),
        .next_channel (next_channel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pause_len();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [9:0] pick_code();
        if ($urandom_range(0, 9) < 2)
        begin
            return edge_codes[$urandom_range(0, 9)];
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic void format_sample_line(input logic [9:0] code);
        logic [3:0] ch;
        logic [7:0] digs [4];
        int         mag;
        int         nd;
        bit         neg;
        neg = 1'b0;
        if (bip_turn)
        begin
            ch = shadow_cfg.uni_ch;
            line_bytes_q.push_back(text_beat_t'{shadow_cfg.marker, 1'b0, ch});
            if (code > 10'd511)
            begin
                neg = 1'b1;
                mag = 1024 - int'(code);
            end
            else
            begin
                mag = int'(code);
            end
        end
        else
        begin
            ch = shadow_cfg.bip_ch;
            mag = int'(code);
        end
        if (neg)
        begin
            line_bytes_q.push_back(text_beat_t'{asaf_pkg::AsciiMinus, 1'b0, ch});
            neg_lines++;
        end
        nd = 0;
        do
        begin
            digs[nd] = asaf_pkg::AsciiZero + 8'(mag % 10);
            mag = mag / 10;
            nd++;
        end
        while (mag != 0);
        for (int i = nd - 1; i >= 0; i--)
        begin
            line_bytes_q.push_back(text_beat_t'{digs[i], 1'b0, ch});
        end
        line_bytes_q.push_back(text_beat_t'{shadow_cfg.line_end, 1'b1, ch});
        bip_turn = ~bip_turn;
        lines_sent++;
    endfunction

    function automatic void apply_setting(input asaf_pkg::cfg_index_t idx,
                                          input logic [7:0] d);
        case (idx)
            asaf_pkg::CFG_MARKER:   shadow_cfg.marker   = d;
            asaf_pkg::CFG_LINE_END: shadow_cfg.line_end = d;
            asaf_pkg::CFG_UNI_CH:   shadow_cfg.uni_ch   = d[3:0];
            asaf_pkg::CFG_BIP_CH:   shadow_cfg.bip_ch   = d[3:0];
            default:                ;
        endcase
    endfunction

    task automatic send_sample(input logic [9:0] code, input string txt, input logic [3:0] ch);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        sample_code <= code;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (txt.len() == 0)
        begin
            format_sample_line(code);
        end
        else
        begin
            for (int i = 0; i < txt.len(); i++)
            begin
                line_bytes_q.push_back(text_beat_t'{txt[i], i == txt.len() - 1, ch});
            end
            if (txt[1] == "-")
            begin
                neg_lines++;
            end
            bip_turn = ~bip_turn;
            lines_sent++;
        end
    endtask

    task automatic load_settings(input logic [7:0] mk, input logic [7:0] le,
                                 input logic [3:0] uc, input logic [3:0] bc);
        logic [7:0] vals [4];
        vals[0] = mk;
        vals[1] = le;
        vals[2] = {4'($urandom), uc};
        vals[3] = {4'($urandom), bc};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= asaf_pkg::cfg_index_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            apply_setting(asaf_pkg::cfg_index_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (line_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        drain();
        repeat (8) @(posedge clk);
    endtask

    // The result side: checks every beat against the oldest expected byte and paces pop.
    initial
    begin
        text_beat_t exp_beat;
        int         stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (line_bytes_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual byte %h", $time,
                             text_byte);
                    fail_count++;
                end
                else
                begin
                    exp_beat = line_bytes_q.pop_front();
                    bytes_checked++;
                    if (text_byte !== exp_beat.chr)
                    begin
                        $display("%0t: text_byte expected %h actual %h", $time, exp_beat.chr,
                                 text_byte);
                        fail_count++;
                    end
                    if (line_done !== exp_beat.done)
                    begin
                        $display("%0t: line_done expected %b actual %b", $time, exp_beat.done,
                                 line_done);
                        fail_count++;
                    end
                    if (next_channel !== exp_beat.ch)
                    begin
                        $display("%0t: next_channel expected %h actual %h", $time, exp_beat.ch,
                                 next_channel);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                stall_left = pause_len();
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        shadow_cfg = '{asaf_pkg::MarkerReset, asaf_pkg::LineEndReset, asaf_pkg::UniChReset,
                       asaf_pkg::BipChReset};
        bip_turn   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DirRows; i++)
        begin
            send_sample(dir_code[i], dir_text[i], dir_ch[i]);
        end
        settle();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       load_settings(8'h00, 8'hFF, 4'h0, 4'hF);
                1:       load_settings(8'hFF, 8'h00, 4'hF, 4'h0);
                4:       load_settings(asaf_pkg::MarkerReset, asaf_pkg::LineEndReset,
                                       asaf_pkg::UniChReset, asaf_pkg::BipChReset);
                default: load_settings(8'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
            endcase
            no_gaps = (p == 4);
            for (int n = 0; n < 55; n++)
            begin
                send_sample(pick_code(), "", 4'd0);
                if ((p == 0 && n == 27) || $urandom_range(0, 39) == 0)
                begin
                    drain();
                end
            end
            settle();
        end

        $display("Framed %0d samples (%0d negative) into %0d checked bytes", lines_sent,
                 neg_lines, bytes_checked);
        $display("under %0d register settings, with and without idle gaps.", settings_used + 1);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/asaf_pkg.sv
rtl/asaf_front.sv
rtl/asaf_fifo.sv
rtl/asaf_back.sv
rtl/adc_sample_ascii_framer.sv
rtl/asaf_checker.sv
tb/sv/tb_top.sv
